// ===== hw/rtl/coulomb_lj_pair_force_assert.svh =====
// Assertion macros for the pair force engine.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef COULOMB_LJ_PAIR_FORCE_ASSERT_SVH
`define COULOMB_LJ_PAIR_FORCE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CLJ_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define CLJ_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== hw/rtl/clj_pkg.sv =====
// Shared types and constants of the pair force engine.
// No dependencies; imported by every module of the block.
package clj_pkg;

	localparam int POS_FRAC    = 16;
	localparam int FORCE_WIDTH = 32;
	localparam int FORCE_FRAC  = 16;
	localparam int FACTOR_FRAC = 32;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam int PADDR_W = 3;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PAIR = 1'b1;

	localparam logic [PADDR_W-3:0] REG_COULOMB = '0;
	localparam logic [31:0] COULOMB_RESET = 32'd1392775686;

	typedef struct packed {
		logic               cmd;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic signed [15:0] charge;
		logic [15:0]        sigma;
		logic [15:0]        epsilon;
		logic               excluded;
	} atom_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic               skipped;
		logic               saturated;
	} result_t;

	// Classified pair item, as held in the queue.
	typedef struct packed {
		logic             excluded;
		logic [2:0]       dneg;
		logic [2:0][23:0] dmag;
		logic             qneg;
		logic [15:0]      qh;
		logic [15:0]      qp;
		logic [15:0]      eh;
		logic [15:0]      ep;
		logic [16:0]      ssum;
	} pair_t;

	typedef struct packed {
		logic            valid;
		logic            full;
		logic [Q_CW-1:0] count;
	} q_stat_t;

endpackage

// ===== hw/rtl/clj_front.sv =====
// Front end: holds the home atom and turns pair items into queue entries.
// Depends on clj_pkg.
module clj_front import clj_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  atom_t atom,
	output logic  push,
	output pair_t pair
);

	logic signed [2:0][23:0] hpos_q;
	logic signed [15:0]      hq_q;
	logic [15:0]             hs_q;
	logic [15:0]             he_q;
	logic signed [2:0][23:0] ppos;
	logic signed [24:0]      d;

	assign ppos = {atom.pos_z, atom.pos_y, atom.pos_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpos_q <= '0;
			hq_q   <= '0;
			hs_q   <= '0;
			he_q   <= '0;
		end else if (accept && atom.cmd == CMD_LOAD) begin
			hpos_q <= ppos;
			hq_q   <= atom.charge;
			hs_q   <= atom.sigma;
			he_q   <= atom.epsilon;
		end
	end

	assign push = accept && atom.cmd == CMD_PAIR;

	// delta = home - partner, kept as sign and magnitude
	always_comb begin
		pair = '0;
		for (int i = 0; i < 3; i++) begin
			d = {hpos_q[i][23], hpos_q[i]} - {ppos[i][23], ppos[i]};
			pair.dneg[i] = d[24];
			pair.dmag[i] = d[24] ? 24'(-d) : d[23:0];
		end
		pair.excluded = atom.excluded;
		pair.qneg = hq_q[15] != atom.charge[15];
		pair.qh   = hq_q[15] ? 16'(-hq_q) : hq_q;
		pair.qp   = atom.charge[15] ? 16'(-atom.charge) : atom.charge;
		pair.eh   = he_q;
		pair.ep   = atom.epsilon;
		pair.ssum = {1'b0, hs_q} + {1'b0, atom.sigma};
	end

endmodule

// ===== hw/rtl/clj_queue.sv =====
// Short queue between the front end and the force pipeline.
// Depends on clj_pkg.
module clj_queue import clj_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  pair_t   wdata,
	input  logic    pop,
	output pair_t   head,
	output q_stat_t stat
);

	pair_t           mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + Q_CW'(push) - Q_CW'(pop);
		end
	end

	assign head       = mem_q[rd_q];
	assign stat.valid = count_q != '0;
	assign stat.full  = count_q == Q_CW'(Q_DEPTH);
	assign stat.count = count_q;

endmodule

// ===== hw/rtl/clj_back.sv =====
// Force pipeline: distance, square roots, reciprocal, LJ and Coulomb terms.
// Depends on clj_pkg; the last stage is the result register.
module clj_back import clj_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] coulomb,
	input  pair_t       head,
	input  logic        head_valid,
	input  logic        stall,
	output logic        pop,
	output logic        valid,
	output result_t     result
);

	localparam int SQ_STEPS = 32;
	localparam int DIV_BITS = 39 + POS_FRAC;
	localparam int S_SQR    = 1;
	localparam int S_SUM    = 2;
	localparam int S_RT0    = 3;
	localparam int S_DV0    = S_RT0 + SQ_STEPS;
	localparam int S_M1     = S_DV0 + DIV_BITS;
	localparam int S_DIFF   = S_M1 + 10;
	localparam int S_M6     = S_DIFF + 1;
	localparam int S_COMB   = S_M6 + 4;
	localparam int S_M8     = S_COMB + 1;
	localparam int S_LAST   = S_M8 + 2;
	localparam int F_SHIFT  = FACTOR_FRAC + POS_FRAC - FORCE_FRAC;
	localparam logic [63:0] SAT = '1;

	typedef logic [3:0][63:0] pp_t;

	typedef struct packed {
		logic [63:0] x;
		logic [63:0] res;
	} sq_t;

	typedef struct packed {
		logic             skip;
		logic [2:0]       dneg;
		logic [2:0][23:0] dmag;
		logic             qneg;
		logic [15:0]      qh;
		logic [15:0]      qp;
		logic [15:0]      eh;
		logic [15:0]      ep;
		logic [16:0]      ssum;
		logic [2:0][47:0] dsq;
		logic [31:0]      qmag;
		logic [31:0]      eprod;
		logic [63:0]      cq;
		logic [63:0]      ssq;
		sq_t              sa;
		sq_t              sb;
		logic [31:0]      rem;
		logic [63:0]      quo;
		logic [63:0]      inv_r2;
		logic [63:0]      inv_r3;
		logic [63:0]      sr2;
		logic [63:0]      sr4;
		logic [63:0]      sr6;
		logic [63:0]      sr12;
		logic [63:0]      diff;
		logic             lneg;
		logic [63:0]      eps24;
		logic [63:0]      t;
		logic [63:0]      lmag;
		logic [63:0]      cmag;
		logic [63:0]      tmag;
		logic             tneg;
		pp_t              ppa;
		pp_t              ppb;
		pp_t [2:0]        ppf;
		logic [2:0][63:0] fm;
		logic [2:0][31:0] fout;
		logic             fsat;
	} bk_t;

	// Four 32x32 partial products of a 64x64 product.
	function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
		pp_t p;
		p[0] = 64'(a[31:0]) * 64'(b[31:0]);
		p[1] = 64'(a[31:0]) * 64'(b[63:32]);
		p[2] = 64'(a[63:32]) * 64'(b[31:0]);
		p[3] = 64'(a[63:32]) * 64'(b[63:32]);
		return p;
	endfunction

	// Sum partial products, shift right, saturate to all ones.
	function automatic logic [63:0] mul_fin(input pp_t p, input int unsigned s);
		logic [63:0]  mid;
		logic [63:0]  hi;
		logic [127:0] full;
		mid  = {32'd0, p[0][63:32]} + {32'd0, p[1][31:0]} + {32'd0, p[2][31:0]};
		hi   = p[3] + {32'd0, p[1][63:32]} + {32'd0, p[2][63:32]} + {32'd0, mid[63:32]};
		full = {hi, mid[31:0], p[0][31:0]} >> s;
		if ((hi >> s) != '0) begin
			return SAT;
		end
		return full[63:0];
	endfunction

	// One step of the digit-by-digit square root.
	function automatic sq_t sq_step(input sq_t v, input logic [63:0] bit_w);
		sq_t o;
		o = v;
		if (v.x >= v.res + bit_w) begin
			o.x   = v.x - (v.res + bit_w);
			o.res = (v.res >> 1) + bit_w;
		end else begin
			o.res = v.res >> 1;
		end
		return o;
	endfunction

	bk_t               bk_s [S_LAST+1];
	logic [S_LAST:0]   vld_s;
	logic              en;
	bk_t               hd_in;

	// Whole pipeline holds while the result waits on a stalled receiver.
	assign en  = !(vld_s[S_LAST] && stall);
	assign pop = en && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[S_LAST-1:0], head_valid};
		end
	end

	always_comb begin
		hd_in      = '0;
		hd_in.skip = head.excluded;
		hd_in.dneg = head.dneg;
		hd_in.dmag = head.dmag;
		hd_in.qneg = head.qneg;
		hd_in.qh   = head.qh;
		hd_in.qp   = head.qp;
		hd_in.eh   = head.eh;
		hd_in.ep   = head.ep;
		hd_in.ssum = head.ssum;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bk_s[0] <= hd_in;
		end
	end

	for (genvar k = 1; k <= S_LAST; k++) begin : g_stg
		localparam int RI = (k >= S_RT0 && k < S_DV0) ? k - S_RT0 : 0;
		localparam int DJ = (k >= S_DV0 && k < S_M1) ? k - S_DV0 : 1;
		localparam logic [63:0] BIT_W = 64'd1 << (62 - 2 * RI);
		bk_t nxt;

		always_comb begin
			logic [49:0] r2;
			logic [32:0] rem2;
			logic [32:0] rqx;
			logic [63:0] pos2;
			logic [63:0] m;
			logic [63:0] lim;
			logic        neg;
			r2   = '0;
			rem2 = '0;
			rqx  = '0;
			pos2 = '0;
			m    = '0;
			lim  = '0;
			neg  = 1'b0;
			nxt  = bk_s[k-1];
			if (k == S_SQR) begin
				for (int i = 0; i < 3; i++) begin
					nxt.dsq[i] = 48'(nxt.dmag[i]) * 48'(nxt.dmag[i]);
				end
				nxt.qmag  = 32'(nxt.qh) * 32'(nxt.qp);
				nxt.eprod = 32'(nxt.eh) * 32'(nxt.ep);
			end else if (k == S_SUM) begin
				r2 = 50'(nxt.dsq[0]) + 50'(nxt.dsq[1]) + 50'(nxt.dsq[2]);
				nxt.skip   = nxt.skip || r2 == '0;
				nxt.cq     = 64'(coulomb) * 64'(nxt.qmag);
				nxt.ssq    = 64'(nxt.ssum) * 64'(nxt.ssum);
				nxt.sa.x   = {2'd0, r2, 12'd0};
				nxt.sa.res = '0;
				nxt.sb.x   = {12'd0, nxt.eprod, 20'd0};
				nxt.sb.res = '0;
				nxt.rem    = '0;
				nxt.quo    = '0;
			end else if (k >= S_RT0 && k < S_DV0) begin
				nxt.sa = sq_step(nxt.sa, BIT_W);
				nxt.sb = sq_step(nxt.sb, BIT_W);
			end else if (k >= S_DV0 && k < S_M1) begin
				// dividend is a single one at its top bit
				rem2 = {nxt.rem, DJ == 0};
				rqx  = {1'b0, nxt.sa.res[31:0]};
				if (rem2 >= rqx) begin
					rem2    = rem2 - rqx;
					nxt.quo = {nxt.quo[62:0], 1'b1};
				end else begin
					nxt.quo = {nxt.quo[62:0], 1'b0};
				end
				nxt.rem = rem2[31:0];
			end else if (k == S_M1) begin
				nxt.ppa = mul_pp(nxt.quo, nxt.quo);
			end else if (k == S_M1 + 1) begin
				nxt.inv_r2 = mul_fin(nxt.ppa, FACTOR_FRAC);
			end else if (k == S_M1 + 2) begin
				nxt.ppa = mul_pp(nxt.inv_r2, nxt.quo);
				nxt.ppb = mul_pp(nxt.ssq, nxt.inv_r2);
			end else if (k == S_M1 + 3) begin
				nxt.inv_r3 = mul_fin(nxt.ppa, FACTOR_FRAC);
				nxt.sr2    = mul_fin(nxt.ppb, 26);
			end else if (k == S_M1 + 4) begin
				nxt.ppa = mul_pp(nxt.cq, nxt.inv_r3);
				nxt.ppb = mul_pp(nxt.sr2, nxt.sr2);
			end else if (k == S_M1 + 5) begin
				nxt.cmag = mul_fin(nxt.ppa, 50);
				nxt.sr4  = mul_fin(nxt.ppb, FACTOR_FRAC);
			end else if (k == S_M1 + 6) begin
				nxt.ppb = mul_pp(nxt.sr4, nxt.sr2);
			end else if (k == S_M1 + 7) begin
				nxt.sr6 = mul_fin(nxt.ppb, FACTOR_FRAC);
			end else if (k == S_M1 + 8) begin
				nxt.ppb = mul_pp(nxt.sr6, nxt.sr6);
			end else if (k == S_M1 + 9) begin
				nxt.sr12 = mul_fin(nxt.ppb, FACTOR_FRAC);
			end else if (k == S_DIFF) begin
				pos2 = {nxt.sr12[62:0], 1'b0};
				if (nxt.sr12[63]) begin
					nxt.diff = SAT;
					nxt.lneg = 1'b0;
				end else if (pos2 >= nxt.sr6) begin
					nxt.diff = pos2 - nxt.sr6;
					nxt.lneg = 1'b0;
				end else begin
					nxt.diff = nxt.sr6 - pos2;
					nxt.lneg = 1'b1;
				end
				nxt.eps24 = (nxt.sb.res << 4) + (nxt.sb.res << 3);
			end else if (k == S_M6) begin
				nxt.ppb = mul_pp(nxt.diff, nxt.inv_r2);
			end else if (k == S_M6 + 1) begin
				nxt.t = mul_fin(nxt.ppb, FACTOR_FRAC);
			end else if (k == S_M6 + 2) begin
				nxt.ppb = mul_pp(nxt.t, nxt.eps24);
			end else if (k == S_M6 + 3) begin
				nxt.lmag = mul_fin(nxt.ppb, 24);
			end else if (k == S_COMB) begin
				if (nxt.lmag == SAT) begin
					nxt.tmag = nxt.lmag;
					nxt.tneg = nxt.lneg;
				end else if (nxt.cmag == SAT) begin
					nxt.tmag = nxt.cmag;
					nxt.tneg = nxt.qneg;
				end else if (nxt.qneg == nxt.lneg) begin
					nxt.tmag = (nxt.cmag > SAT - nxt.lmag) ? SAT : nxt.cmag + nxt.lmag;
					nxt.tneg = nxt.qneg;
				end else if (nxt.cmag >= nxt.lmag) begin
					nxt.tmag = nxt.cmag - nxt.lmag;
					nxt.tneg = nxt.qneg;
				end else begin
					nxt.tmag = nxt.lmag - nxt.cmag;
					nxt.tneg = nxt.lneg;
				end
			end else if (k == S_M8) begin
				for (int i = 0; i < 3; i++) begin
					nxt.ppf[i] = mul_pp(64'(nxt.dmag[i]), nxt.tmag);
				end
			end else if (k == S_M8 + 1) begin
				for (int i = 0; i < 3; i++) begin
					nxt.fm[i] = mul_fin(nxt.ppf[i], F_SHIFT);
				end
			end else begin
				// clamp to the force width, then fold in the sign
				nxt.fsat = 1'b0;
				for (int i = 0; i < 3; i++) begin
					m   = nxt.fm[i];
					neg = nxt.dneg[i] != nxt.tneg;
					lim = (64'd1 << (FORCE_WIDTH - 1)) - (neg ? 64'd0 : 64'd1);
					if (m > lim) begin
						m        = lim;
						nxt.fsat = 1'b1;
					end
					nxt.fout[i] = neg ? 32'(64'd0 - m) : m[31:0];
				end
				if (nxt.skip) begin
					nxt.fout = '0;
					nxt.fsat = 1'b0;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				bk_s[k] <= nxt;
			end
		end
	end

	assign valid            = vld_s[S_LAST];
	assign result.force_x   = bk_s[S_LAST].fout[0];
	assign result.force_y   = bk_s[S_LAST].fout[1];
	assign result.force_z   = bk_s[S_LAST].fout[2];
	assign result.skipped   = bk_s[S_LAST].skip;
	assign result.saturated = bk_s[S_LAST].fsat;

endmodule

// ===== hw/rtl/coulomb_lj_pair_force.sv =====
// Lennard-Jones plus Coulomb pair force engine, top level.
// Channels: atom (in) and frc (out), both valid/stall, plus an APB-style
// register port holding the Coulomb constant (unsigned Q10.22).
// A load item (cmd 0) replaces the home atom and gives no result; a pair
// item (cmd 1) gives one result: the force on the home atom in Q16.16.
// Throughput: one item per cycle, sustained while frc_stall is low.
// The force pipeline runs a 32-step square root and a 55-step reciprocal,
// then eight 64-bit multiplies, each a partial-product stage and a sum
// stage, ahead of the result register.
// A four-entry queue parts the front end from the pipeline: when frc is
// stalled the result register and the whole pipeline hold, the queue
// fills, and atom_stall rises once the queue is full.
// Reset clears the home atom to zero, empties the queue and pipeline,
// and loads the default Coulomb constant; no clearing pass is needed.
// Write the Coulomb constant only while the block is idle.
// Depends on clj_pkg, clj_front, clj_queue, clj_back and the assert header.
`include "coulomb_lj_pair_force_assert.svh"

module coulomb_lj_pair_force import clj_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               atom_valid,
	output logic               atom_stall,
	input  atom_t              atom,
	output logic               frc_valid,
	input  logic               frc_stall,
	output result_t            frc
);

	logic [31:0] coulomb_q;
	logic        accept;
	logic        push;
	pair_t       pair;
	pair_t       head;
	q_stat_t     q_stat;
	logic        bk_pop;

	// Register port: a single word, written on the access phase.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coulomb_q <= COULOMB_RESET;
		end else if (psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_COULOMB) begin
			coulomb_q <= pwdata;
		end
	end

	assign prdata = (paddr[PADDR_W-1:2] == REG_COULOMB) ? coulomb_q : 32'd0;

	// Hold the input off only when the queue has no room.
	assign atom_stall = q_stat.full;
	assign accept     = atom_valid && !atom_stall;

	clj_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.atom   (atom),
		.push   (push),
		.pair   (pair)
	);

	clj_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (pair),
		.pop    (bk_pop),
		.head   (head),
		.stat   (q_stat)
	);

	clj_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.coulomb    (coulomb_q),
		.head       (head),
		.head_valid (q_stat.valid),
		.stall      (frc_stall),
		.pop        (bk_pop),
		.valid      (frc_valid),
		.result     (frc)
	);

	`CLJ_ASSERT_IMP(a_skip_zero, frc_valid && frc.skipped, frc.force_x == '0 && frc.force_y == '0 && frc.force_z == '0 && !frc.saturated, "skipped result carries force")
	`CLJ_ASSERT_IMP(a_pop_nonempty, bk_pop, q_stat.valid, "pipeline took from an empty queue")
	`CLJ_ASSERT_NXT(a_load_no_push, accept && atom.cmd == CMD_LOAD && !bk_pop, q_stat.count == $past(q_stat.count), "load item entered the queue")

endmodule

// ===== verif/tb_coulomb_lj_pair_force.sv =====
// Self-checking bench for the Lennard-Jones plus Coulomb pair force engine.
// Holds a scoreboard class with its own fixed-point force predictor;
// depends on clj_pkg and the coulomb_lj_pair_force top level.
module tb_coulomb_lj_pair_force;
	import clj_pkg::*;

	// Predicts each pair force from the home atom it tracks, and holds the
	// forces still owed by the block, oldest first.
	class force_scoreboard;
		logic [31:0]       k_coul;
		logic signed [23:0] home_pos [3];
		logic signed [15:0] home_q;
		logic [15:0]       home_sig;
		logic [15:0]       home_eps;
		result_t           owed_forces [$];
		int                errors;

		function new();
			k_coul = COULOMB_RESET;
			foreach (home_pos[i]) home_pos[i] = '0;
			home_q = '0;
			home_sig = '0;
			home_eps = '0;
			errors = 0;
		endfunction

		// floor(a*b / 2^s), clamped to all ones
		function logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int s);
			logic [127:0] p;
			p = {64'd0, a} * {64'd0, b};
			p = p >> s;
			if (p[127:64] != 0)
				return '1;
			return p[63:0];
		endfunction

		function logic [63:0] int_sqrt(logic [63:0] x);
			logic [63:0] res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > x)
				b = b >> 2;
			while (b != 0) begin
				if (x >= res + b) begin
					x = x - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function logic [63:0] mag(longint v);
			return v < 0 ? -v : v;
		endfunction

		// Note an accepted atom item: load it as home, or owe a pair force.
		function void note_atom(atom_t a);
			longint d [3];
			logic signed [23:0] p [3];
			logic [63:0] r2, rq, inv_r, inv_r2, inv_r3, cmag, lmag, tmag;
			logic [63:0] ssum, sr2, sr6, sr12, pos2, diff, epsm, t, m, lim;
			logic cneg, lneg, tneg, neg;
			result_t r;
			p[0] = a.pos_x;
			p[1] = a.pos_y;
			p[2] = a.pos_z;
			if (a.cmd == CMD_LOAD) begin
				foreach (p[i]) home_pos[i] = p[i];
				home_q = a.charge;
				home_sig = a.sigma;
				home_eps = a.epsilon;
				return;
			end
			r = '0;
			r2 = 0;
			for (int i = 0; i < 3; i++) begin
				d[i] = longint'(home_pos[i]) - longint'(p[i]);
				r2 = r2 + mag(d[i]) * mag(d[i]);
			end
			if (a.excluded || r2 == 0) begin
				r.skipped = 1'b1;
				owed_forces.push_back(r);
				return;
			end
			rq = int_sqrt(r2 << 12);
			inv_r = (64'd1 << (38 + POS_FRAC)) / rq;
			inv_r2 = mul_shr(inv_r, inv_r, FACTOR_FRAC);
			inv_r3 = mul_shr(inv_r2, inv_r, FACTOR_FRAC);
			// Coulomb magnitude; repulsive when the charges share a sign
			cmag = mul_shr({32'd0, k_coul} * (mag(home_q) * mag(a.charge)), inv_r3, 50);
			cneg = (home_q < 0) != (a.charge < 0);
			// Lennard-Jones with arithmetic-mean sigma
			ssum = home_sig + a.sigma;
			sr2 = mul_shr(ssum * ssum, inv_r2, 26);
			sr6 = mul_shr(mul_shr(sr2, sr2, FACTOR_FRAC), sr2, FACTOR_FRAC);
			sr12 = mul_shr(sr6, sr6, FACTOR_FRAC);
			pos2 = sr12 > 64'h7FFF_FFFF_FFFF_FFFF ? '1 : sr12 * 2;
			if (pos2 == '1) begin
				diff = '1;
				lneg = 1'b0;
			end else if (pos2 >= sr6) begin
				diff = pos2 - sr6;
				lneg = 1'b0;
			end else begin
				diff = sr6 - pos2;
				lneg = 1'b1;
			end
			epsm = int_sqrt((64'(home_eps) * a.epsilon) << 20);
			t = mul_shr(diff, inv_r2, FACTOR_FRAC);
			lmag = mul_shr(t, epsm * 24, 24);
			// a clamped term decides the total, the LJ one first
			if (lmag == '1) begin
				tmag = lmag; tneg = lneg;
			end else if (cmag == '1) begin
				tmag = cmag; tneg = cneg;
			end else if (cneg == lneg) begin
				tmag = (cmag > ~lmag) ? '1 : cmag + lmag;
				tneg = cneg;
			end else if (cmag >= lmag) begin
				tmag = cmag - lmag; tneg = cneg;
			end else begin
				tmag = lmag - cmag; tneg = lneg;
			end
			for (int i = 0; i < 3; i++) begin
				m = mul_shr(mag(d[i]), tmag, FACTOR_FRAC + POS_FRAC - FORCE_FRAC);
				neg = (d[i] < 0) != tneg;
				lim = (64'd1 << (FORCE_WIDTH - 1)) - (neg ? 0 : 1);
				if (m > lim) begin
					m = lim;
					r.saturated = 1'b1;
				end
				m = neg ? -m : m;
				case (i)
					0: r.force_x = m[31:0];
					1: r.force_y = m[31:0];
					default: r.force_z = m[31:0];
				endcase
			end
			owed_forces.push_back(r);
		endfunction

		function void check_force(result_t got);
			result_t exp_r;
			if (owed_forces.size() == 0) begin
				$error("force result with none owed: %h", got);
				errors++;
				return;
			end
			exp_r = owed_forces.pop_front();
			if (got.force_x !== exp_r.force_x) begin
				$error("force_x expected %h got %h", exp_r.force_x, got.force_x);
				errors++;
			end
			if (got.force_y !== exp_r.force_y) begin
				$error("force_y expected %h got %h", exp_r.force_y, got.force_y);
				errors++;
			end
			if (got.force_z !== exp_r.force_z) begin
				$error("force_z expected %h got %h", exp_r.force_z, got.force_z);
				errors++;
			end
			if (got.skipped !== exp_r.skipped) begin
				$error("skipped expected %b got %b", exp_r.skipped, got.skipped);
				errors++;
			end
			if (got.saturated !== exp_r.saturated) begin
				$error("saturated expected %b got %b", exp_r.saturated, got.saturated);
				errors++;
			end
		endfunction
	endclass

	localparam int LATENCY = 120;
	localparam int STALL_LIMIT = 4000;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata, prdata;
	logic               pready;
	logic               atom_valid, atom_stall;
	atom_t              atom;
	logic               frc_valid, frc_stall;
	result_t            frc;

	force_scoreboard sb;
	bit              steady;   // long stretch with no idling on either side
	int              quiet_cycles;

	coulomb_lj_pair_force u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.atom_valid(atom_valid), .atom_stall(atom_stall), .atom(atom),
		.frc_valid(frc_valid), .frc_stall(frc_stall), .frc(frc)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Stall the force channel at random; none during the steady stretch.
	always @(negedge clk) begin
		frc_stall <= !steady && ($urandom_range(99) < 33);
	end

	// Check every accepted force item against the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && frc_valid && !frc_stall)
			sb.check_force(frc);
	end

	// Watchdog: count cycles with no item moving on either channel.
	always @(posedge clk) begin
		if ((atom_valid && !atom_stall) || (frc_valid && !frc_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Present one item, idling first at random, and hold it until accepted.
	task automatic send_atom(atom_t a);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 33) begin
			atom_valid = 1'b0;
			atom = atom_t'($bits(atom_t)'({$urandom, $urandom, $urandom, $urandom}));
			@(negedge clk);
		end
		atom_valid = 1'b1;
		atom = a;
		do @(posedge clk); while (atom_stall);
		sb.note_atom(a);
	endtask

	// Drop valid and wait until every owed force has arrived, then let the
	// pipeline drain for any trailing load items.
	task automatic drain();
		@(negedge clk);
		atom_valid = 1'b0;
		while (sb.owed_forces.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_coulomb(logic [31:0] v);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = {REG_COULOMB, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.k_coul = v;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	function automatic atom_t make_atom(logic c, int x, int y, int z, int q,
			int s, int e, logic ex);
		atom_t a;
		a.cmd = c;
		a.pos_x = 24'(x);
		a.pos_y = 24'(y);
		a.pos_z = 24'(z);
		a.charge = 16'(q);
		a.sigma = 16'(s);
		a.epsilon = 16'(e);
		a.excluded = ex;
		return a;
	endfunction

	function automatic int near(int centre, int spread);
		return centre + $urandom_range(2 * spread) - spread;
	endfunction

	// Random well-formed run: a home load then several partners close to it,
	// with now and then a fully random item.
	task automatic random_phase(int n_items);
		int hx, hy, hz, spread, sent;
		sent = 0;
		while (sent < n_items) begin
			hx = near(0, 1 << 20);
			hy = near(0, 1 << 20);
			hz = near(0, 1 << 20);
			send_atom(make_atom(CMD_LOAD, hx, hy, hz, near(0, 16384),
				$urandom_range(65535), $urandom_range(65535), 1'($urandom_range(1))));
			sent++;
			repeat ($urandom_range(8, 1)) begin
				if ($urandom_range(9) == 0) begin
					send_atom(atom_t'($bits(atom_t)'({$urandom, $urandom, $urandom,
						$urandom})));
				end else begin
					// mostly small sigma so the force is not always clamped
					spread = 1 << $urandom_range(22, 12);
					send_atom(make_atom(CMD_PAIR, near(hx, spread), near(hy, spread),
						near(hz, spread), near(0, 16384),
						$urandom_range(1) ? $urandom_range(16383) : $urandom_range(65535),
						$urandom_range(65535), $urandom_range(19) == 0));
				end
				sent++;
			end
			if (sent % 200 < 9)
				steady = !steady;
		end
	endtask

	initial begin
		sb = new();
		steady = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		atom_valid = 1'b0;
		atom = '0;
		frc_stall = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: pair against the reset home, coincident, excluded,
		// opposite and equal charges, extreme positions, huge sigma.
		send_atom(make_atom(CMD_PAIR, 65536, 0, 0, 16384, 4096, 16384, 1'b0));
		send_atom(make_atom(CMD_PAIR, 0, 0, 0, 0, 0, 0, 1'b0));
		send_atom(make_atom(CMD_LOAD, 0, 0, 0, 16384, 4096, 16384, 1'b0));
		send_atom(make_atom(CMD_PAIR, 0, 0, 0, -16384, 4096, 16384, 1'b0));
		send_atom(make_atom(CMD_PAIR, 196608, 0, 0, -16384, 4096, 16384, 1'b0));
		send_atom(make_atom(CMD_PAIR, 196608, 0, 0, -16384, 4096, 16384, 1'b1));
		send_atom(make_atom(CMD_PAIR, 0, -196608, 65536, 16384, 4096, 16384, 1'b0));
		send_atom(make_atom(CMD_PAIR, 1, 0, 0, 16384, 65535, 65535, 1'b0));
		send_atom(make_atom(CMD_PAIR, 0, 2, -1, -16384, 0, 0, 1'b0));
		send_atom(make_atom(CMD_PAIR, 8388607, -8388608, 8388607, 16384, 65535, 65535,
			1'b0));
		send_atom(make_atom(CMD_PAIR, 131072, 131072, 131072, 0, 0, 65535, 1'b0));
		send_atom(make_atom(CMD_LOAD, -8388608, 8388607, -8388608, -16384, 65535, 65535,
			1'b1));
		send_atom(make_atom(CMD_PAIR, 8388607, -8388608, 8388607, -16384, 65535, 65535,
			1'b0));
		send_atom(make_atom(CMD_PAIR, -8388608, 8388607, -8388608, 16384, 0, 0, 1'b0));
		send_atom(make_atom(CMD_PAIR, -8388000, 8388000, -8388608, 16384, 65535, 65535,
			1'b0));
		send_atom(make_atom(CMD_PAIR, -8000000, 8000000, -8000000, -1, 1, 1, 1'b0));
		random_phase(150);
		drain();

		write_coulomb(32'd0);
		random_phase(150);
		drain();
		write_coulomb(32'hFFFF_FFFF);
		random_phase(150);
		drain();
		write_coulomb($urandom);
		random_phase(150);
		drain();
		write_coulomb(COULOMB_RESET);
		random_phase(100);
		drain();

		if (sb.errors == 0 && sb.owed_forces.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
